// ===== rtl/qcc_pkg.sv =====
package qcc_pkg;

   localparam int MAX_STRIDE = 32;
   localparam int POS_W = $clog2(MAX_STRIDE);
   localparam int CNT_W = $clog2(MAX_STRIDE + 1);
   localparam int SYM_W = 8;
   localparam int KIND_W = 3;
   localparam int COST_W = 8;
   localparam int COVER_W = 6;
   localparam int STRIDE_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = (STRIDE_W > SYM_W) ? STRIDE_W : SYM_W;
   localparam int BITS_PER_SYM = 6;
   localparam int COST_BASE = 2;
   localparam int COST_SHORT = 2;
   localparam int COST_CALC_W = CNT_W + 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPEAT  = 3'd0,
      KIND_RUN_A   = 3'd1,
      KIND_RUN_B   = 3'd2,
      KIND_LITERAL = 3'd3,
      KIND_TAIL    = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIDE      = 2'd0,
      CSR_FIRST_FREQ  = 2'd1,
      CSR_SECOND_FREQ = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [STRIDE_W-1:0] stride;
      logic [SYM_W-1:0]    first_freq;
      logic [SYM_W-1:0]    second_freq;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [COST_W-1:0]   cost_bits;
      logic [COVER_W-1:0]  covered;
      logic                done;
   } result_type;

   function automatic logic [CNT_W-1:0] eff_stride(input logic [STRIDE_W-1:0] stride);
      if (stride == '0) begin
         return CNT_W'(1);
      end else if (int'(stride) > MAX_STRIDE) begin
         return CNT_W'(MAX_STRIDE);
      end else begin
         return CNT_W'(stride);
      end
   endfunction

   function automatic logic [COST_W-1:0] literal_cost(input logic [CNT_W-1:0] n);
      logic [COST_CALC_W-1:0] c;
      c = COST_CALC_W'(n) * COST_CALC_W'(BITS_PER_SYM) + COST_CALC_W'(COST_BASE);
      if (c > COST_CALC_W'({COST_W{1'b1}})) begin
         return '1;
      end else begin
         return COST_W'(c);
      end
   endfunction

   function automatic logic [COVER_W-1:0] covered_count(input logic [CNT_W-1:0] n);
      if (int'(n) > (1 << COVER_W) - 1) begin
         return '1;
      end else begin
         return COVER_W'(n);
      end
   endfunction

endpackage

// ===== rtl/qcc_req_if.sv =====
interface qcc_req_if;
   logic                       valid;
   logic                       ready;
   logic [qcc_pkg::SYM_W-1:0]  symbol;
   logic                       line_end;

   modport source (output valid, output symbol, output line_end, input ready);
   modport sink (input valid, input symbol, input line_end, output ready);
endinterface

// ===== rtl/qcc_rsp_if.sv =====
interface qcc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [qcc_pkg::KIND_W-1:0]   kind;
   logic [qcc_pkg::COST_W-1:0]   cost_bits;
   logic [qcc_pkg::COVER_W-1:0]  symbols_covered;
   logic                         line_done;

   modport source (output valid, output kind, output cost_bits, output symbols_covered,
                   output line_done, input ready);
   modport sink (input valid, input kind, input cost_bits, input symbols_covered,
                 input line_done, output ready);
endinterface

// ===== rtl/quality_chunk_classifier.sv =====
// a word is accepted into the input register and goes through a single pass of compare
// and classify logic; a word that closes a chunk or ends the line has its result
// registered in the result register on rsp_chan; one word per cycle is accepted, and a
// held result stalls the input only once both registers are full
// reset (synchronous, active high) clears line state, stride to 5 and the frequent
// chars to 0 and 1; chunk store contents are left unknown and are never read unwritten
module quality_chunk_classifier (
   input  logic                           clock,
   input  logic                           reset,
   qcc_req_if.sink                        req_chan,
   qcc_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [qcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qcc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   qcc_pkg::cfg_type cfg_ff, cfg_in;

   logic                       in_valid_ff, in_valid_in;
   logic [qcc_pkg::SYM_W-1:0]  in_symbol_ff;
   logic                       in_line_end_ff;

   logic                       out_valid_ff;
   qcc_pkg::result_type        out_ff;

   qcc_pkg::result_type        res;
   logic                       advance;
   logic                       fire;
   logic                       accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (qcc_pkg::csr_index_type'(csr_index))
            qcc_pkg::CSR_STRIDE:      cfg_in.stride = qcc_pkg::STRIDE_W'(csr_wdata);
            qcc_pkg::CSR_FIRST_FREQ:  cfg_in.first_freq = qcc_pkg::SYM_W'(csr_wdata);
            qcc_pkg::CSR_SECOND_FREQ: cfg_in.second_freq = qcc_pkg::SYM_W'(csr_wdata);
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stride      <= qcc_pkg::STRIDE_W'(5);
         cfg_ff.first_freq  <= '0;
         cfg_ff.second_freq <= qcc_pkg::SYM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // result register frees up when empty or being taken
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_symbol_ff   <= req_chan.symbol;
         in_line_end_ff <= req_chan.line_end;
      end
   end

   qcc_classify u_classify (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .symbol   (in_symbol_ff),
      .line_end (in_line_end_ff),
      .cfg      (cfg_ff),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= fire && res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res.valid) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.kind            = out_ff.kind;
   assign rsp_chan.cost_bits       = out_ff.cost_bits;
   assign rsp_chan.symbols_covered = out_ff.covered;
   assign rsp_chan.line_done       = out_ff.done;

   a_short_cost: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && ((out_ff.kind == qcc_pkg::KIND_REPEAT)
                       || (out_ff.kind == qcc_pkg::KIND_RUN_A)
                       || (out_ff.kind == qcc_pkg::KIND_RUN_B))
      |-> (out_ff.cost_bits == qcc_pkg::COST_W'(qcc_pkg::COST_SHORT)))
      else $error("short chunk kind with wrong cost");

   a_input_word_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_symbol_ff)
                                  && $stable(in_line_end_ff))
      else $error("stalled input word lost");

endmodule

// ===== rtl/qcc_chunk_store.sv =====
// two banks: one collects the current chunk, the other holds the previous one
module qcc_chunk_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic                       bank_sel,
   input  logic [qcc_pkg::POS_W-1:0]  pos,
   input  logic [qcc_pkg::SYM_W-1:0]  wr_data,
   output logic [qcc_pkg::SYM_W-1:0]  rd_data
);

   logic [qcc_pkg::SYM_W-1:0] bank0_ff [qcc_pkg::MAX_STRIDE];
   logic [qcc_pkg::SYM_W-1:0] bank1_ff [qcc_pkg::MAX_STRIDE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (bank_sel) begin
            bank1_ff[pos] <= wr_data;
         end else begin
            bank0_ff[pos] <= wr_data;
         end
      end
   end

   assign rd_data = bank_sel ? bank0_ff[pos] : bank1_ff[pos];

endmodule

// ===== rtl/qcc_classify.sv =====
module qcc_classify (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [qcc_pkg::SYM_W-1:0]  symbol,
   input  logic                       line_end,
   input  qcc_pkg::cfg_type           cfg,
   output qcc_pkg::result_type        res
);

   logic [qcc_pkg::POS_W-1:0]  fill_ff, fill_in;
   logic                       prev_valid_ff, prev_valid_in;
   logic [qcc_pkg::CNT_W-1:0]  prev_len_ff, prev_len_in;
   logic [qcc_pkg::SYM_W-1:0]  run_a_ff, run_a_in;
   logic [qcc_pkg::SYM_W-1:0]  run_b_ff, run_b_in;
   logic [qcc_pkg::SYM_W-1:0]  first_ff, first_in;
   logic [2:0]                 flags_ff, flags_in;
   logic                       in_line_ff, in_line_in;
   logic                       bank_ff, bank_in;

   logic [qcc_pkg::SYM_W-1:0]  prev_byte;
   logic [qcc_pkg::SYM_W-1:0]  ra, rb, first_byte;
   logic [2:0]                 base;
   logic                       m_prev, m_a, m_b;
   logic [qcc_pkg::CNT_W-1:0]  n;
   logic                       close;

   qcc_chunk_store u_store (
      .clock    (clock),
      .wr_en    (fire),
      .bank_sel (bank_ff),
      .pos      (fill_ff),
      .wr_data  (symbol),
      .rd_data  (prev_byte)
   );

   always_comb begin
      ra         = in_line_ff ? run_a_ff : cfg.first_freq;
      rb         = in_line_ff ? run_b_ff : cfg.second_freq;
      first_byte = (fill_ff == '0) ? symbol : first_ff;
      base       = (fill_ff == '0) ? 3'b111 : flags_ff;
      // bit0 equals previous chunk, bit1 all equal a, bit2 all equal b
      m_prev     = base[0] && prev_valid_ff && (qcc_pkg::CNT_W'(fill_ff) < prev_len_ff)
                   && (prev_byte == symbol);
      m_a        = base[1] && (symbol == ra);
      m_b        = base[2] && (symbol == rb);
      n          = qcc_pkg::CNT_W'(fill_ff) + qcc_pkg::CNT_W'(1);
      close      = (n >= qcc_pkg::eff_stride(cfg.stride));

      fill_in       = fill_ff;
      prev_valid_in = prev_valid_ff;
      prev_len_in   = prev_len_ff;
      run_a_in      = run_a_ff;
      run_b_in      = run_b_ff;
      first_in      = first_ff;
      flags_in      = flags_ff;
      in_line_in    = in_line_ff;
      bank_in       = bank_ff;

      res.valid     = 1'b0;
      res.kind      = qcc_pkg::KIND_LITERAL;
      res.cost_bits = qcc_pkg::literal_cost(n);
      res.covered   = qcc_pkg::covered_count(n);
      res.done      = line_end;

      if (fire) begin
         first_in   = first_byte;
         flags_in   = {m_b, m_a, m_prev};
         run_a_in   = ra;
         run_b_in   = rb;
         in_line_in = 1'b1;
         fill_in    = qcc_pkg::POS_W'(n);

         if (close) begin
            res.valid = 1'b1;
            // a chunk opening on a but not all a stays literal, unless it repeats the previous chunk
            if (m_prev && (n == prev_len_ff)) begin
               res.kind = qcc_pkg::KIND_REPEAT;
            end else if (m_a) begin
               res.kind = qcc_pkg::KIND_RUN_A;
            end else if (first_byte == ra) begin
               res.kind = qcc_pkg::KIND_LITERAL;
            end else if (m_b) begin
               res.kind = qcc_pkg::KIND_RUN_B;
            end else begin
               res.kind = qcc_pkg::KIND_LITERAL;
            end
            if (res.kind != qcc_pkg::KIND_LITERAL) begin
               res.cost_bits = qcc_pkg::COST_W'(qcc_pkg::COST_SHORT);
            end

            if (first_byte == symbol) begin
               run_a_in = (first_byte == cfg.first_freq) ? cfg.second_freq : cfg.first_freq;
            end
            run_b_in = symbol;
            fill_in  = '0;

            if (line_end) begin
               prev_valid_in = 1'b0;
               prev_len_in   = '0;
               flags_in      = 3'b111;
               in_line_in    = 1'b0;
            end else begin
               prev_valid_in = 1'b1;
               prev_len_in   = n;
               bank_in       = ~bank_ff;
            end
         end else if (line_end) begin
            res.valid     = 1'b1;
            res.kind      = qcc_pkg::KIND_TAIL;
            fill_in       = '0;
            prev_valid_in = 1'b0;
            prev_len_in   = '0;
            flags_in      = 3'b111;
            in_line_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         prev_valid_ff <= 1'b0;
         prev_len_ff   <= '0;
         run_a_ff      <= '0;
         run_b_ff      <= qcc_pkg::SYM_W'(1);
         first_ff      <= '0;
         flags_ff      <= 3'b111;
         in_line_ff    <= 1'b0;
         bank_ff       <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         prev_valid_ff <= prev_valid_in;
         prev_len_ff   <= prev_len_in;
         run_a_ff      <= run_a_in;
         run_b_ff      <= run_b_in;
         first_ff      <= first_in;
         flags_ff      <= flags_in;
         in_line_ff    <= in_line_in;
         bank_ff       <= bank_in;
      end
   end

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && line_end |=> !in_line_ff && !prev_valid_ff && (fill_ff == '0))
      else $error("line end did not clear line state");

   a_prev_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      prev_valid_ff |-> (prev_len_ff != '0))
      else $error("previous chunk valid with zero length");

   a_tail_closes_line: assert property (@(posedge clock) disable iff (reset)
      res.valid && (res.kind == qcc_pkg::KIND_TAIL) |-> res.done)
      else $error("tail result without line done");

endmodule
